@@ sv/xor_checked_frame_receiver_assert.svh @@
// Assertion macros used by the frame receiver checker.
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Condition must hold whenever the reset is released.
`define XCFR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Overlapping implication checked every cycle outside reset.
`define XCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every cycle outside reset.
`define XCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/xcfr_pkg.sv @@
// Types and codes shared by the frame receiver modules.
package xcfr_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_TOKEN_BYTE = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_OK        = 3'd1,
    KIND_BAD_START = 3'd2,
    KIND_BAD_TOKEN = 3'd3,
    KIND_BAD_SUM   = 3'd4
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  seq_num;
    logic [15:0] msg_length;
    logic        frame_end;
  } result_t;

endpackage

@@ sv/xcfr_parser.sv @@
// Frame parser: phase, running checksum, header fields and payload countdown.
module xcfr_parser import xcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] start_byte_i,
  input  logic [7:0] token_byte_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [15:0] left_dec;
  logic [15:0] len_lo;

  assign left_dec = left_q - 16'd1;
  assign len_lo   = {len_q[15:8], rx_byte_i};

  always_comb begin
    phase_d = phase_q;
    xor_d   = xor_q;
    seq_d   = seq_q;
    len_d   = len_q;
    left_d  = left_q;
    res_o   = '0;
    res_o.seq_num    = seq_q;
    res_o.msg_length = len_q;
    unique case (phase_q)
      PH_SEQ: begin
        seq_d   = rx_byte_i;
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {rx_byte_i, 8'h00};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = len_lo;
        left_d  = len_lo;
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (rx_byte_i != token_byte_i) begin
          phase_d           = PH_IDLE;
          res_o.valid       = 1'b1;
          res_o.result_kind = KIND_BAD_TOKEN;
          res_o.frame_end   = 1'b1;
        end else begin
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = (left_q == 16'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        xor_d             = xor_q ^ rx_byte_i;
        left_d            = left_dec;
        phase_d           = (left_dec == 16'd0) ? PH_CHECK : PH_DATA;
        res_o.valid       = 1'b1;
        res_o.result_kind = KIND_DATA;
        res_o.data_byte   = rx_byte_i;
      end
      PH_CHECK: begin
        phase_d           = PH_IDLE;
        res_o.valid       = 1'b1;
        res_o.result_kind = (rx_byte_i == xor_q) ? KIND_OK : KIND_BAD_SUM;
        res_o.frame_end   = 1'b1;
      end
      default: begin
        // idle, and the unused phase code
        if (rx_byte_i != start_byte_i) begin
          phase_d           = PH_IDLE;
          res_o.valid       = 1'b1;
          res_o.result_kind = KIND_BAD_START;
          res_o.seq_num     = 8'h00;
          res_o.msg_length  = 16'h0000;
          res_o.frame_end   = 1'b1;
        end else begin
          xor_d   = rx_byte_i;
          seq_d   = 8'h00;
          len_d   = 16'h0000;
          left_d  = 16'h0000;
          phase_d = PH_SEQ;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      xor_q   <= 8'h00;
      seq_q   <= 8'h00;
      len_q   <= 16'h0000;
      left_q  <= 16'h0000;
    end else if (fire_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ sv/xcfr_out_reg.sv @@
// Result register with valid/stall handshake toward the consumer.
module xcfr_out_reg import xcfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    stall_i,
  output logic    ready_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

endmodule

@@ sv/xor_checked_frame_receiver.sv @@
// Receiver for XOR-checked serial frames: start, seq, length, token, payload, checksum.
// Takes one received byte per cycle with no gaps of its own while the result port
// is not stalled. An accepted byte sits in the input register, is parsed once the
// result register can take it and, if it yields a result, is registered there and
// shows on the result port. The phase, checksum and payload countdown update
// together when the byte is parsed, so each byte sees the state left by the
// one before it. Payload bytes come out as they arrive (kind 0); every frame
// ends with exactly one frame-ok, bad-start, bad-token or bad-checksum beat.
// Start and token bytes are set through the config port (indexes 0 and 1,
// reset 27 and 14); other indexes are ignored, and the port is always ready.
module xor_checked_frame_receiver import xcfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [2:0]         result_kind_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         seq_num_o,
  output logic [15:0]        msg_length_o,
  output logic               frame_end_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic [7:0] start_byte_q;
  logic [7:0] token_byte_q;
  logic       out_ready;
  logic       fire;
  logic       rx_take;
  result_t    parse_res;
  result_t    out_res;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && out_ready;
  assign rx_stall_o  = in_valid_q && !fire;
  assign rx_take     = rx_valid_i && !rx_stall_o;

  always_comb begin
    if (rx_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd27;
      token_byte_q <= 8'd14;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_START_BYTE) begin
        start_byte_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_TOKEN_BYTE) begin
        token_byte_q <= cfg_data_i;
      end
    end
  end

  xcfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .rx_byte_i    (in_byte_q),
    .start_byte_i (start_byte_q),
    .token_byte_i (token_byte_q),
    .res_o        (parse_res)
  );

  xcfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && parse_res.valid),
    .res_i   (parse_res),
    .stall_i (res_stall_i),
    .ready_o (out_ready),
    .res_o   (out_res)
  );

  assign res_valid_o   = out_res.valid;
  assign result_kind_o = out_res.result_kind;
  assign data_byte_o   = out_res.data_byte;
  assign seq_num_o     = out_res.seq_num;
  assign msg_length_o  = out_res.msg_length;
  assign frame_end_o   = out_res.frame_end;

endmodule

@@ sv/xcfr_checker.sv @@
// Port-level checker for the frame receiver, bound to the top level.
`include "xor_checked_frame_receiver_assert.svh"

module xcfr_checker import xcfr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_o,
  input logic               res_stall_i,
  input logic [2:0]         result_kind_o,
  input logic [7:0]         data_byte_o,
  input logic [7:0]         seq_num_o,
  input logic [15:0]        msg_length_o,
  input logic               frame_end_o
);

  `XCFR_ASSERT_IMPL(a_end_matches_kind, res_valid_o, frame_end_o == (result_kind_o != KIND_DATA), "frame_end disagrees with result kind")
  `XCFR_ASSERT_IMPL(a_data_zero_off_payload, res_valid_o && (result_kind_o != KIND_DATA), data_byte_o == 8'h00, "data byte set on a non-payload beat")
  `XCFR_ASSERT_IMPL(a_bad_start_no_header, res_valid_o && (result_kind_o == KIND_BAD_START), (seq_num_o == 8'h00) && (msg_length_o == 16'h0000), "bad start carries header fields")
  `XCFR_ASSERT_NEXT(a_res_hold, res_valid_o && res_stall_i, res_valid_o && $stable(result_kind_o) && $stable(data_byte_o) && $stable(msg_length_o), "stalled result beat changed")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (.*);
